[rtl/dtmf_pkg.sv]
`default_nettype none

package dtmf_pkg;

   localparam int PHASE_BITS  = 10;
   localparam int INDEX_BITS  = 32;
   localparam int QUARTER     = 1 << (PHASE_BITS - 2);
   localparam int SINE_W      = 15;
   localparam int FREQ_W      = 11;
   localparam int SR_W        = 17;
   localparam int VOL_W       = 6;
   localparam int EVENT_W     = 8;
   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 15;
   localparam int TONE_SEL_W  = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 17;
   localparam int QUEUE_DEPTH = 4;
   localparam int RSP_DEPTH   = 4;

   localparam logic [EVENT_W-1:0] EVENT_PAUSE     = 8'hff;
   localparam logic [EVENT_W-1:0] NUM_TONE_EVENTS = 8'd16;

   localparam logic [VOL_W-1:0] VOLUME_RESET   = 6'd10;
   localparam logic [SR_W-1:0]  PCM_RATE_RESET = 17'd8000;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOLUME   = 1'b0,
      CSR_PCM_RATE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                  tone;
      logic                  unsup;
      logic                  last;
      logic [FREQ_W-1:0]     row_hz;
      logic [FREQ_W-1:0]     col_hz;
      logic [INDEX_BITS-1:0] idx;
   } job_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       unsupported;
      logic                       end_of_run;
   } rsp_type;

   localparam logic [FREQ_W-1:0] ROW_HZ [16] = '{
      11'd941, 11'd697, 11'd697, 11'd697, 11'd770, 11'd770, 11'd770, 11'd852,
      11'd852, 11'd852, 11'd941, 11'd941, 11'd697, 11'd770, 11'd852, 11'd941
   };

   localparam logic [FREQ_W-1:0] COL_HZ [16] = '{
      11'd1336, 11'd1209, 11'd1336, 11'd1477, 11'd1209, 11'd1336, 11'd1477, 11'd1209,
      11'd1336, 11'd1477, 11'd1209, 11'd1477, 11'd1633, 11'd1633, 11'd1633, 11'd1633
   };

   localparam logic [GAIN_W-1:0] GAIN_ROM [64] = '{
      15'd32767, 15'd29204, 15'd26028, 15'd23197, 15'd20675, 15'd18426, 15'd16422,
      15'd14636, 15'd13045, 15'd11626, 15'd10362, 15'd9235, 15'd8231, 15'd7336,
      15'd6538, 15'd5827, 15'd5193, 15'd4628, 15'd4125, 15'd3677, 15'd3277,
      15'd2920, 15'd2603, 15'd2320, 15'd2067, 15'd1843, 15'd1642, 15'd1464,
      15'd1304, 15'd1163, 15'd1036, 15'd924, 15'd823, 15'd734, 15'd654, 15'd583,
      15'd519, 15'd463, 15'd413, 15'd368, 15'd328, 15'd292, 15'd260, 15'd232,
      15'd207, 15'd184, 15'd164, 15'd146, 15'd130, 15'd116, 15'd104, 15'd92,
      15'd82, 15'd73, 15'd65, 15'd58, 15'd52, 15'd46, 15'd41, 15'd37,
      15'd33, 15'd29, 15'd26, 15'd23
   };

   typedef logic [QUARTER:0][SINE_W-1:0] sine_rom_type;

   // Q30 Taylor series of sin(pi/2 * k/QUARTER), rounded to Q15
   function automatic logic [SINE_W-1:0] quarter_sine(longint unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned acc;
      longint unsigned res;
      x    = (k * HALF_PI_Q30) >> (PHASE_BITS - 2);
      x2   = (x * x) >> 30;
      term = x;
      acc  = x;
      term = ((term * x2) >> 30) / 6;
      acc  = (acc >= term) ? acc - term : 64'd0;
      term = ((term * x2) >> 30) / 20;
      acc  = acc + term;
      term = ((term * x2) >> 30) / 42;
      acc  = (acc >= term) ? acc - term : 64'd0;
      term = ((term * x2) >> 30) / 72;
      acc  = acc + term;
      term = ((term * x2) >> 30) / 110;
      acc  = (acc >= term) ? acc - term : 64'd0;
      term = ((term * x2) >> 30) / 156;
      acc  = acc + term;
      term = ((term * x2) >> 30) / 210;
      acc  = (acc >= term) ? acc - term : 64'd0;
      res  = (acc + 64'd16384) >> 15;
      if (res > 64'd32767) begin
         res = 64'd32767;
      end
      return res[SINE_W-1:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int k = 0; k <= QUARTER; k++) begin
         rom[k] = quarter_sine(longint'(k));
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

[rtl/dtmf_fifo.sv]
`default_nettype none

module dtmf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/dtmf_divpipe.sv]
`default_nettype none

// Pipelined restoring division, one quotient bit per stage.
// Each lane starts from a partial remainder below the divisor.
module dtmf_divpipe #(
   parameter int STEPS  = 8,
   parameter int LANES  = 1,
   parameter int DIV_W  = 17,
   parameter int SIDE_W = 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic                              in_valid,
   input  wire logic [LANES-1:0][DIV_W-1:0]       in_rem,
   input  wire logic [LANES-1:0][STEPS-1:0]       in_bits,
   input  wire logic [SIDE_W-1:0]                 in_side,
   input  wire logic [DIV_W-1:0]                  divisor,
   output logic                                   out_valid,
   output logic      [LANES-1:0][DIV_W-1:0]       out_rem,
   output logic      [LANES-1:0][STEPS-1:0]       out_quo,
   output logic      [SIDE_W-1:0]                 out_side
);

   logic [LANES-1:0][DIV_W-1:0] rem_ff    [STEPS];
   logic [LANES-1:0][DIV_W-1:0] rem_in    [STEPS];
   logic [LANES-1:0][DIV_W-1:0] rem_prev  [STEPS];
   logic [LANES-1:0][STEPS-1:0] work_ff   [STEPS];
   logic [LANES-1:0][STEPS-1:0] work_in   [STEPS];
   logic [LANES-1:0][STEPS-1:0] work_prev [STEPS];
   logic [SIDE_W-1:0]           side_ff   [STEPS];
   logic [SIDE_W-1:0]           side_prev [STEPS];
   logic [STEPS-1:0]            valid_ff;
   logic [STEPS-1:0]            valid_prev;

   for (genvar s = 0; s < STEPS; s++) begin : g_link
      if (s == 0) begin : g_head
         assign rem_prev[s]   = in_rem;
         assign work_prev[s]  = in_bits;
         assign side_prev[s]  = in_side;
         assign valid_prev[s] = in_valid;
      end else begin : g_body
         assign rem_prev[s]   = rem_ff[s-1];
         assign work_prev[s]  = work_ff[s-1];
         assign side_prev[s]  = side_ff[s-1];
         assign valid_prev[s] = valid_ff[s-1];
      end
   end

   // work register: dividend bits leave at the top, quotient bits enter at the bottom
   always_comb begin
      logic [DIV_W:0] trial;
      logic [DIV_W:0] diff;
      for (int s = 0; s < STEPS; s++) begin
         for (int l = 0; l < LANES; l++) begin
            trial = {rem_prev[s][l], work_prev[s][l][STEPS-1]};
            diff  = trial - {1'b0, divisor};
            if (trial >= {1'b0, divisor}) begin
               rem_in[s][l]  = diff[DIV_W-1:0];
               work_in[s][l] = {work_prev[s][l][STEPS-2:0], 1'b1};
            end else begin
               rem_in[s][l]  = trial[DIV_W-1:0];
               work_in[s][l] = {work_prev[s][l][STEPS-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < STEPS; s++) begin
            rem_ff[s]  <= rem_in[s];
            work_ff[s] <= work_in[s];
            side_ff[s] <= side_prev[s];
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_rem   = rem_ff[STEPS-1];
   assign out_quo   = work_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

`default_nettype wire

[rtl/dtmf_front.sv]
`default_nettype none

module dtmf_front #(
   parameter int QUEUE_DEPTH = dtmf_pkg::QUEUE_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic [dtmf_pkg::EVENT_W-1:0]        req_event_req,
   input  wire logic [dtmf_pkg::INDEX_BITS-1:0]     req_sample_index,
   input  wire logic                                req_last_of_run,
   input  wire logic                                job_pop,
   output logic                                     job_valid,
   output dtmf_pkg::job_type                        job
);

   dtmf_pkg::job_type                  job_in;
   logic                               job_empty;
   logic [dtmf_pkg::TONE_SEL_W-1:0]    sel;

   assign sel = req_event_req[dtmf_pkg::TONE_SEL_W-1:0];

   always_comb begin
      job_in.tone   = (req_event_req < dtmf_pkg::NUM_TONE_EVENTS);
      job_in.unsup  = !job_in.tone && (req_event_req != dtmf_pkg::EVENT_PAUSE);
      job_in.last   = req_last_of_run;
      job_in.row_hz = dtmf_pkg::ROW_HZ[sel];
      job_in.col_hz = dtmf_pkg::COL_HZ[sel];
      job_in.idx    = req_sample_index;
   end

   dtmf_fifo #(
      .WIDTH ($bits(dtmf_pkg::job_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (job_in),
      .full      (req_full),
      .pop       (job_pop),
      .pop_data  (job),
      .empty     (job_empty)
   );

   assign job_valid = !job_empty;

endmodule

`default_nettype wire

[rtl/dtmf_back.sv]
`default_nettype none

module dtmf_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          job_valid,
   input  wire dtmf_pkg::job_type             job,
   output logic                               job_pop,
   input  wire logic [dtmf_pkg::VOL_W-1:0]    volume,
   input  wire logic [dtmf_pkg::SR_W-1:0]     pcm_rate,
   input  wire logic                          out_full,
   output logic                               out_push,
   output dtmf_pkg::rsp_type                  out_item
);

   localparam int PB     = dtmf_pkg::PHASE_BITS;
   localparam int SR_W   = dtmf_pkg::SR_W;
   localparam int FREQ_W = dtmf_pkg::FREQ_W;
   localparam int PROD_W = FREQ_W + SR_W;
   localparam int STEPS2 = FREQ_W + PB;
   localparam int SW     = dtmf_pkg::SAMPLE_W;
   localparam int GW     = dtmf_pkg::GAIN_W;
   localparam int MAG_W  = SW;

   typedef struct packed {
      logic              tone;
      logic              unsup;
      logic              last;
      logic [FREQ_W-1:0] row_hz;
      logic [FREQ_W-1:0] col_hz;
   } tone_side_type;

   typedef struct packed {
      logic tone;
      logic unsup;
      logic last;
   } flag_type;

   logic                               en;
   tone_side_type                      d1_side_in;
   tone_side_type                      d1_side;
   logic                               d1_valid;
   logic [SR_W-1:0]                    d1_rem;

   logic                               m_valid_ff;
   logic [1:0][PROD_W-1:0]             m_prod_ff, m_prod_in;
   flag_type                           m_side_ff;

   logic [1:0][SR_W-1:0]               d2_rem0;
   logic [1:0][STEPS2-1:0]             d2_bits;
   logic [1:0][STEPS2-1:0]             d2_quo;
   flag_type                           d2_side;
   logic                               d2_valid;

   logic                               t_valid_ff;
   logic signed [1:0][SW-1:0]          t_sine_ff, t_sine_in;
   flag_type                           t_side_ff;

   logic                               u_valid_ff;
   logic [MAG_W-1:0]                   u_mag_ff, u_mag_in;
   logic                               u_neg_ff, u_neg_in;
   flag_type                           u_side_ff;

   logic                               g_valid_ff;
   logic [GW-1:0]                      g_scaled_ff, g_scaled_in;
   logic                               g_neg_ff;
   flag_type                           g_side_ff;

   // whole pipeline holds while its last stage cannot drain
   assign en       = !(g_valid_ff && out_full);
   assign job_pop  = en && job_valid;
   assign out_push = g_valid_ff && !out_full;

   assign d1_side_in = '{tone:   job.tone,
                         unsup:  job.unsup,
                         last:   job.last,
                         row_hz: job.row_hz,
                         col_hz: job.col_hz};

   // index mod rate
   dtmf_divpipe #(
      .STEPS  (dtmf_pkg::INDEX_BITS),
      .LANES  (1),
      .DIV_W  (SR_W),
      .SIDE_W ($bits(tone_side_type))
   ) u_index_mod (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (job_valid),
      .in_rem    ('0),
      .in_bits   (job.idx),
      .in_side   (d1_side_in),
      .divisor   (pcm_rate),
      .out_valid (d1_valid),
      .out_rem   (d1_rem),
      .out_quo   (),
      .out_side  (d1_side)
   );

   always_comb begin
      m_prod_in[0] = {{SR_W{1'b0}}, d1_side.row_hz} * {{FREQ_W{1'b0}}, d1_rem};
      m_prod_in[1] = {{SR_W{1'b0}}, d1_side.col_hz} * {{FREQ_W{1'b0}}, d1_rem};
   end

   // product < 2^FREQ_W * rate, so its top SR_W bits are already reduced
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         d2_rem0[l] = m_prod_ff[l][PROD_W-1 -: SR_W];
         d2_bits[l] = {m_prod_ff[l][FREQ_W-1:0], {PB{1'b0}}};
      end
   end

   // low PB quotient bits are the tone phase
   dtmf_divpipe #(
      .STEPS  (STEPS2),
      .LANES  (2),
      .DIV_W  (SR_W),
      .SIDE_W ($bits(flag_type))
   ) u_phase_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m_valid_ff),
      .in_rem    (d2_rem0),
      .in_bits   (d2_bits),
      .in_side   (m_side_ff),
      .divisor   (pcm_rate),
      .out_valid (d2_valid),
      .out_rem   (),
      .out_quo   (d2_quo),
      .out_side  (d2_side)
   );

   always_comb begin
      logic [PB-1:0]                ph;
      logic [1:0]                   quad;
      logic [PB-2:0]                off;
      logic [PB-2:0]                tidx;
      logic [dtmf_pkg::SINE_W-1:0]  ent;
      logic signed [SW-1:0]         val;
      for (int l = 0; l < 2; l++) begin
         ph   = d2_quo[l][PB-1:0];
         quad = ph[PB-1 -: 2];
         off  = {1'b0, ph[PB-3:0]};
         tidx = quad[0] ? ((PB-1)'(dtmf_pkg::QUARTER) - off) : off;
         ent  = dtmf_pkg::SINE_ROM[tidx];
         val  = $signed({1'b0, ent});
         t_sine_in[l] = quad[1] ? -val : val;
      end
   end

   always_comb begin
      logic signed [SW:0] sum;
      logic signed [SW:0] mag;
      sum      = {t_sine_ff[0][SW-1], t_sine_ff[0]} + {t_sine_ff[1][SW-1], t_sine_ff[1]};
      mag      = sum[SW] ? -sum : sum;
      u_neg_in = sum[SW];
      u_mag_in = mag[MAG_W-1:0];
   end

   always_comb begin
      logic [MAG_W+GW-1:0] prod;
      prod        = {{GW{1'b0}}, u_mag_ff} * {{MAG_W{1'b0}}, dtmf_pkg::GAIN_ROM[volume]};
      g_scaled_in = prod[MAG_W+GW-1 -: GW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         t_valid_ff <= 1'b0;
         u_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= d1_valid;
         t_valid_ff <= d2_valid;
         u_valid_ff <= t_valid_ff;
         g_valid_ff <= u_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_prod_ff   <= m_prod_in;
         m_side_ff   <= '{tone: d1_side.tone, unsup: d1_side.unsup, last: d1_side.last};
         t_sine_ff   <= t_sine_in;
         t_side_ff   <= d2_side;
         u_mag_ff    <= u_mag_in;
         u_neg_ff    <= u_neg_in;
         u_side_ff   <= t_side_ff;
         g_scaled_ff <= g_scaled_in;
         g_neg_ff    <= u_neg_ff;
         g_side_ff   <= u_side_ff;
      end
   end

   always_comb begin
      logic signed [SW-1:0] pos;
      pos = $signed({1'b0, g_scaled_ff});
      if (g_side_ff.tone && (pcm_rate != '0)) begin
         out_item.sample = g_neg_ff ? -pos : pos;
      end else begin
         out_item.sample = '0;
      end
      out_item.unsupported = g_side_ff.unsup;
      out_item.end_of_run  = g_side_ff.last;
   end

endmodule

`default_nettype wire

[rtl/dtmf_tone_generator.sv]
`default_nettype none

// DTMF dual-tone sample generator.
// Request queue (req_push / req_full): an event code, an absolute sample
// index and a last-of-run mark. Result queue (rsp_empty / rsp_pop): one
// signed 16-bit sample per request, an unsupported-event flag and the
// copied last-of-run mark, in request order.
// CSR port: csr_we with csr_index selects volume (attenuation in dB) or
// the output rate in Hz; write only while no transaction is in flight.
// Throughput: one transaction per clock while the result queue is not full.
// The two bit-per-stage divider pipelines have 32 stages for index mod
// rate and 11 + PHASE_BITS for the phase.
// Reset clears both queues and the pipeline valids and loads volume 10,
// rate 8000. When the receiver stalls the result queue fills, the
// pipeline holds in place, then the request queue fills and req_full rises;
// nothing is dropped.
module dtmf_tone_generator #(
   parameter int QUEUE_DEPTH = dtmf_pkg::QUEUE_DEPTH,
   parameter int RSP_DEPTH   = dtmf_pkg::RSP_DEPTH
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_push,
   output logic                                         req_full,
   input  wire logic        [dtmf_pkg::EVENT_W-1:0]     req_event_req,
   input  wire logic        [dtmf_pkg::INDEX_BITS-1:0]  req_sample_index,
   input  wire logic                                    req_last_of_run,
   output logic                                         rsp_empty,
   input  wire logic                                    rsp_pop,
   output logic signed      [dtmf_pkg::SAMPLE_W-1:0]    rsp_sample,
   output logic                                         rsp_unsupported,
   output logic                                         rsp_end_of_run,
   input  wire logic                                    csr_we,
   input  wire logic        [dtmf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic        [dtmf_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [dtmf_pkg::VOL_W-1:0] volume_ff, volume_in;
   logic [dtmf_pkg::SR_W-1:0]  pcm_rate_ff, pcm_rate_in;

   dtmf_pkg::job_type          job;
   logic                       job_valid;
   logic                       job_pop;
   dtmf_pkg::rsp_type          out_item;
   logic                       out_push;
   logic                       out_full;
   dtmf_pkg::rsp_type          rsp_item;

   always_comb begin
      volume_in   = volume_ff;
      pcm_rate_in = pcm_rate_ff;
      if (csr_we) begin
         unique case (dtmf_pkg::csr_index_type'(csr_index))
            dtmf_pkg::CSR_VOLUME: begin
               volume_in = csr_wdata[dtmf_pkg::VOL_W-1:0];
            end
            dtmf_pkg::CSR_PCM_RATE: begin
               pcm_rate_in = csr_wdata[dtmf_pkg::SR_W-1:0];
            end
            default: begin
               volume_in = volume_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff   <= dtmf_pkg::VOLUME_RESET;
         pcm_rate_ff <= dtmf_pkg::PCM_RATE_RESET;
      end else begin
         volume_ff   <= volume_in;
         pcm_rate_ff <= pcm_rate_in;
      end
   end

   dtmf_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_event_req    (req_event_req),
      .req_sample_index (req_sample_index),
      .req_last_of_run  (req_last_of_run),
      .job_pop          (job_pop),
      .job_valid        (job_valid),
      .job              (job)
   );

   dtmf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid),
      .job         (job),
      .job_pop     (job_pop),
      .volume      (volume_ff),
      .pcm_rate    (pcm_rate_ff),
      .out_full    (out_full),
      .out_push    (out_push),
      .out_item    (out_item)
   );

   dtmf_fifo #(
      .WIDTH ($bits(dtmf_pkg::rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_item),
      .empty     (rsp_empty)
   );

   assign rsp_sample      = rsp_item.sample;
   assign rsp_unsupported = rsp_item.unsupported;
   assign rsp_end_of_run  = rsp_item.end_of_run;

endmodule

`default_nettype wire

[rtl/dtmf_port_asserts.sv]
`default_nettype none

module dtmf_port_asserts (
   input wire logic                                    clock,
   input wire logic                                    reset,
   input wire logic                                    req_full,
   input wire logic                                    rsp_empty,
   input wire logic                                    rsp_pop,
   input wire logic signed [dtmf_pkg::SAMPLE_W-1:0]    rsp_sample,
   input wire logic                                    rsp_unsupported,
   input wire logic                                    rsp_end_of_run
);

   // queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // silence for an unsupported event
   a_unsup_silent: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_unsupported) |-> (rsp_sample == '0))
      else $error("unsupported event gave a nonzero sample");

   // the scaled sum of the two tones never reaches full negative scale
   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_sample != 16'sh8000))
      else $error("sample out of range");

   // a waiting transaction holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_sample) && $stable(rsp_unsupported)
          && $stable(rsp_end_of_run)))
      else $error("result changed while stalled");

endmodule

bind dtmf_tone_generator dtmf_port_asserts u_port_asserts (.*);

`default_nettype wire
